### rtl/sha256_pkg.sv
// Shared types, constants and round functions for the SHA-256 stream hasher.
package sha256_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       is_last;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } out_item_t;

    localparam int unsigned QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_FOLD,
        ST_PAD,
        ST_LEN,
        ST_EMIT
    } core_state_t;

    localparam logic [31:0] INIT_HASH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PAD_BYTE = 8'h80;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_s0(input logic [31:0] x);
        big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_s1(input logic [31:0] x);
        big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_s0(input logic [31:0] x);
        small_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_s1(input logic [31:0] x);
        small_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

### rtl/sha256_stream_hasher_unit.sv
// Top level of the SHA-256 stream hasher: intake queue feeding the engine.
// Takes one message byte per transfer; the queue holds transfers while the
// engine is busy, as the engine takes items only while idle. A block of 64
// bytes is compressed in 64 rounds at one per cycle, then folded into the hash.
// A transfer with is_last adds one or two padding compressions, each made of a
// setup state (pad or length), 64 rounds and a fold, then eight digest
// words leave in order, word 0 first; the engine then returns to the initial hash.
module sha256_stream_hasher_unit #(
    parameter int unsigned QUEUE_DEPTH = sha256_pkg::QUEUE_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sha256_pkg::in_item_t  s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output sha256_pkg::out_item_t m_data
);
    logic                 q_valid, q_ready;
    sha256_pkg::in_item_t q_item;

    sha256_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk, .aresetn,
        .wr_valid(s_valid), .wr_ready(s_ready), .wr_item(s_data),
        .rd_valid(q_valid), .rd_ready(q_ready), .rd_item(q_item)
    );

    sha256_core u_core (
        .aclk, .aresetn,
        .item_valid(q_valid), .item_ready(q_ready), .item(q_item),
        .m_valid, .m_ready, .m_data
    );
endmodule

### rtl/sha256_queue.sv
// Small item queue between the intake and the compression engine.
module sha256_queue #(
    parameter int unsigned DEPTH = sha256_pkg::QUEUE_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_valid,
    output logic                 wr_ready,
    input  sha256_pkg::in_item_t wr_item,
    output logic                 rd_valid,
    input  logic                 rd_ready,
    output sha256_pkg::in_item_t rd_item
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    sha256_pkg::in_item_t mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [AW:0]   count_reg;
    logic          push, pop;

    assign wr_ready = (count_reg != AW'(0) + (AW+1)'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    property p_no_overflow;
        @(posedge aclk) disable iff (!aresetn) count_reg <= (AW+1)'(DEPTH);
    endproperty
    assert property (p_no_overflow) else $error("queue count beyond depth");

    property p_pop_drains;
        @(posedge aclk) disable iff (!aresetn)
            (pop && !push) |=> (count_reg == $past(count_reg) - 1'b1);
    endproperty
    assert property (p_pop_drains) else $error("queue count not decremented");

    property p_push_fills;
        @(posedge aclk) disable iff (!aresetn)
            (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1);
    endproperty
    assert property (p_push_fills) else $error("queue count not incremented");

endmodule

### rtl/sha256_core.sv
// Block assembly, padding, 64-round compression and digest output.
module sha256_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  sha256_pkg::in_item_t  item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output sha256_pkg::out_item_t m_data
);
    sha256_pkg::core_state_t state_reg, state_next;

    logic [31:0] h_reg [8];
    logic [31:0] v_reg [8];
    logic [31:0] w_reg [16];
    logic [63:0] bits_reg;
    logic [5:0]  pos_reg;
    logic [5:0]  round_reg;
    logic [2:0]  widx_reg;
    logic        final_reg;   // current block ends the message; padding and digest follow
    logic        len_pend_reg; // length block still to run after this one
    logic        pad_done_reg; // padding has been placed for the current message

    logic        take;
    logic [31:0] w15, w2, w7, wsched, wr, t1, t2, ch, maj;
    logic [3:0]  ri;

    assign ri     = round_reg[3:0];
    assign w15    = w_reg[4'(ri + 4'd1)];
    assign w2     = w_reg[4'(ri + 4'd14)];
    assign w7     = w_reg[4'(ri + 4'd9)];
    assign wsched = sha256_pkg::small_s0(w15) + sha256_pkg::small_s1(w2) + w_reg[ri] + w7;
    assign wr     = (round_reg < 6'd16) ? w_reg[ri] : wsched;
    assign ch     = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign maj    = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t1     = v_reg[7] + sha256_pkg::big_s1(v_reg[4]) + ch
                    + sha256_pkg::ROUND_K[round_reg] + wr;
    assign t2     = sha256_pkg::big_s0(v_reg[0]) + maj;

    assign item_ready = (state_reg == sha256_pkg::ST_IDLE);
    assign take       = item_valid && item_ready;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sha256_pkg::ST_IDLE: begin
                if (take) begin
                    if (item.has_byte && pos_reg == 6'd63) begin
                        state_next = sha256_pkg::ST_ROUND;
                    end else if (item.is_last) begin
                        state_next = sha256_pkg::ST_PAD;
                    end
                end
            end
            sha256_pkg::ST_ROUND: begin
                if (round_reg == 6'd63) begin
                    state_next = sha256_pkg::ST_FOLD;
                end
            end
            sha256_pkg::ST_FOLD: begin
                if (len_pend_reg) begin
                    state_next = sha256_pkg::ST_LEN;
                end else if (final_reg && !pad_done_reg) begin
                    // a full block that ended the message still needs padding
                    state_next = sha256_pkg::ST_PAD;
                end else if (final_reg) begin
                    state_next = sha256_pkg::ST_EMIT;
                end else begin
                    state_next = sha256_pkg::ST_IDLE;
                end
            end
            sha256_pkg::ST_PAD: begin
                state_next = sha256_pkg::ST_ROUND;
            end
            sha256_pkg::ST_LEN: begin
                state_next = sha256_pkg::ST_ROUND;
            end
            sha256_pkg::ST_EMIT: begin
                if (m_ready && widx_reg == 3'd7) begin
                    state_next = sha256_pkg::ST_IDLE;
                end
            end
            default: state_next = sha256_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        m_valid            = (state_reg == sha256_pkg::ST_EMIT);
        m_data.digest_word = h_reg[widx_reg];
        m_data.word_index  = widx_reg;
        m_data.last_word   = (widx_reg == 3'd7);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= sha256_pkg::ST_IDLE;
            final_reg    <= 1'b0;
            len_pend_reg <= 1'b0;
            pos_reg      <= '0;
            bits_reg     <= '0;
            round_reg    <= '0;
            widx_reg     <= '0;
            for (int i = 0; i < 8; i++) begin
                h_reg[i] <= sha256_pkg::INIT_HASH[i];
                v_reg[i] <= '0;
            end
            for (int i = 0; i < 16; i++) begin
                w_reg[i] <= '0;
            end
        end else begin
            state_reg <= state_next;
            case (state_reg)
                sha256_pkg::ST_IDLE: begin
                    round_reg <= '0;
                    if (take) begin
                        final_reg <= item.is_last;
                        if (item.has_byte) begin
                            w_reg[pos_reg[5:2]][8*(3-pos_reg[1:0]) +: 8] <= item.data_byte;
                            bits_reg <= bits_reg + 64'd8;
                            pos_reg  <= pos_reg + 1'b1;
                        end
                        if (item.has_byte && pos_reg == 6'd63) begin
                            // full block: pad after it if last
                            len_pend_reg <= 1'b0;
                            for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
                        end
                    end
                end
                sha256_pkg::ST_PAD: begin
                    // pad byte goes at pos; decide if length fits
                    w_reg[pos_reg[5:2]][8*(3-pos_reg[1:0]) +: 8] <= sha256_pkg::PAD_BYTE;
                    pos_reg <= '0;
                    for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
                    if (pos_reg >= 6'd56) begin
                        len_pend_reg <= 1'b1;
                    end else begin
                        len_pend_reg <= 1'b0;
                        w_reg[14] <= bits_reg[63:32];
                        w_reg[15] <= bits_reg[31:0];
                    end
                end
                sha256_pkg::ST_LEN: begin
                    len_pend_reg <= 1'b0;
                    w_reg[14] <= bits_reg[63:32];
                    w_reg[15] <= bits_reg[31:0];
                    for (int i = 0; i < 8; i++) v_reg[i] <= h_reg[i];
                end
                sha256_pkg::ST_ROUND: begin
                    if (round_reg >= 6'd16) begin
                        w_reg[ri] <= wsched;
                    end
                    v_reg[7] <= v_reg[6];
                    v_reg[6] <= v_reg[5];
                    v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2];
                    v_reg[2] <= v_reg[1];
                    v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                    round_reg <= round_reg + 1'b1;
                end
                sha256_pkg::ST_FOLD: begin
                    for (int i = 0; i < 8; i++) h_reg[i] <= h_reg[i] + v_reg[i];
                    for (int i = 0; i < 16; i++) w_reg[i] <= '0;
                    round_reg <= '0;
                end
                sha256_pkg::ST_EMIT: begin
                    if (m_ready) begin
                        widx_reg <= widx_reg + 1'b1;
                        if (widx_reg == 3'd7) begin
                            for (int i = 0; i < 8; i++) begin
                                h_reg[i] <= sha256_pkg::INIT_HASH[i];
                                v_reg[i] <= '0;
                            end
                            bits_reg  <= '0;
                            pos_reg   <= '0;
                            final_reg <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pad_done_reg <= 1'b0;
        end else if (state_reg == sha256_pkg::ST_PAD) begin
            pad_done_reg <= 1'b1;
        end else if (state_reg == sha256_pkg::ST_IDLE) begin
            pad_done_reg <= 1'b0;
        end
    end

    property p_round_bounded;
        @(posedge aclk) disable iff (!aresetn)
            (state_reg == sha256_pkg::ST_ROUND && round_reg == 6'd63)
            |=> (state_reg == sha256_pkg::ST_FOLD);
    endproperty
    assert property (p_round_bounded) else $error("compression did not end after 64 rounds");

    property p_emit_holds;
        @(posedge aclk) disable iff (!aresetn)
            (m_valid && !m_ready) |=> (m_valid && $stable(widx_reg));
    endproperty
    assert property (p_emit_holds) else $error("digest word changed while stalled");

    property p_no_intake_busy;
        @(posedge aclk) disable iff (!aresetn)
            (state_reg != sha256_pkg::ST_IDLE) |-> !item_ready;
    endproperty
    assert property (p_no_intake_busy) else $error("item taken while engine busy");

endmodule

### test/tb.sv
// Testbench for the SHA-256 stream hasher: queue-fed driver, monitor, digest predictor.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT = 2000000;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    sha256_pkg::in_item_t  s_data;
    logic                  m_valid;
    logic                  m_ready;
    sha256_pkg::out_item_t m_data;

    sha256_stream_hasher_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    sha256_pkg::in_item_t  pending_bytes[$];
    sha256_pkg::out_item_t digest_words[$];
    int        error_count;
    int        cycle_count;
    int        items_queued;
    bit        hold_sender;
    bit        in_taken;

    // predictor state
    logic [31:0] hv[8];
    logic [31:0] blk[16];
    logic [63:0] msg_bits;
    logic [5:0]  fill_pos;

    function automatic logic [31:0] ror32(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic hash_clear();
        hv = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
               32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
        foreach (blk[i]) blk[i] = '0;
        msg_bits = '0;
        fill_pos = '0;
    endtask

    task automatic compress_block();
        logic [31:0] v[8];
        logic [31:0] w, w15, w2, t1, t2;
        for (int i = 0; i < 8; i++) v[i] = hv[i];
        for (int r = 0; r < 64; r++) begin
            if (r < 16) begin
                w = blk[r];
            end else begin
                w15 = blk[(r + 1) & 15];
                w2 = blk[(r + 14) & 15];
                w = (ror32(w15, 7) ^ ror32(w15, 18) ^ (w15 >> 3))
                  + (ror32(w2, 17) ^ ror32(w2, 19) ^ (w2 >> 10))
                  + blk[r & 15] + blk[(r + 9) & 15];
                blk[r & 15] = w;
            end
            t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::ROUND_K[r] + w;
            t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hv[i] += v[i];
        foreach (blk[i]) blk[i] = '0;
    endtask

    task automatic place_byte(logic [7:0] b);
        blk[fill_pos[5:2]][(3 - fill_pos[1:0]) * 8 +: 8] = b;
        fill_pos = fill_pos + 6'd1;
    endtask

    task automatic absorb_item(sha256_pkg::in_item_t it);
        sha256_pkg::out_item_t o;
        if (it.has_byte) begin
            place_byte(it.data_byte);
            msg_bits += 64'd8;
            if (fill_pos == 0) compress_block();
        end
        if (!it.is_last) return;
        place_byte(sha256_pkg::PAD_BYTE);
        if (fill_pos > 56 || fill_pos == 0) begin
            compress_block();
            fill_pos = 0;
        end
        blk[14] = msg_bits[63:32];
        blk[15] = msg_bits[31:0];
        compress_block();
        for (int i = 0; i < 8; i++) begin
            o.digest_word = hv[i];
            o.word_index = 3'(i);
            o.last_word = (i == 7);
            digest_words.push_back(o);
        end
        hash_clear();
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] mismatch %s: got %h expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic int pick_gap();
        if ($urandom_range(0, 2) == 0) return 0;
        if ($urandom_range(0, 15) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    initial begin
        aclk = 0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        aresetn = 0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;
    end

    // driver: predict on each accepted transfer
    int send_gap;
    bit gaps_on;
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 0;
            s_data <= '0;
            send_gap = 0;
        end else begin
            if (in_taken) begin
                absorb_item(s_data);
                void'(pending_bytes.pop_front());
            end
            if (!s_valid || in_taken) begin
                if (send_gap > 0 && gaps_on) send_gap--;
                if ((send_gap == 0 || !gaps_on) && !hold_sender
                    && pending_bytes.size() > 0) begin
                    s_valid <= 1;
                    s_data <= pending_bytes[0];
                    send_gap = pick_gap();
                end else begin
                    s_valid <= 0;
                end
            end
        end
    end

    // monitor: compare on rising edge, note input transfers for the driver
    always @(posedge aclk) begin
        sha256_pkg::out_item_t want;
        cycle_count++;
        in_taken = aresetn && s_valid && s_ready;
        if (aresetn && m_valid && m_ready) begin
            if (digest_words.size() == 0) begin
                report_mismatch("unexpected word", m_data.digest_word, '0);
            end else begin
                want = digest_words.pop_front();
                if (m_data.digest_word !== want.digest_word)
                    report_mismatch("digest_word", m_data.digest_word, want.digest_word);
                if (m_data.word_index !== want.word_index)
                    report_mismatch("word_index", m_data.word_index, want.word_index);
                if (m_data.last_word !== want.last_word)
                    report_mismatch("last_word", m_data.last_word, want.last_word);
            end
        end
    end

    // receiver stall
    int stall_left;
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 0;
            stall_left = 0;
        end else if (!gaps_on) begin
            m_ready <= 1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 0;
        end else begin
            m_ready <= 1;
            if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
        end
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Verification failed");
        $finish;
    end

    task automatic push_item(sha256_pkg::in_item_t it);
        pending_bytes.push_back(it);
        items_queued++;
    endtask

    task automatic add_message(int len, bit empty_last);
        sha256_pkg::in_item_t it;
        for (int i = 0; i < len; i++) begin
            it.data_byte = 8'($urandom);
            it.has_byte = 1;
            it.is_last = (i == len - 1) && !empty_last;
            push_item(it);
            if ($urandom_range(0, 9) == 0) begin
                it.has_byte = 0;
                it.is_last = 0;
                it.data_byte = 8'($urandom);
                push_item(it);
            end
        end
        if (empty_last || len == 0) begin
            it.data_byte = 8'($urandom);
            it.has_byte = 0;
            it.is_last = 1;
            push_item(it);
        end
    endtask

    task automatic drain();
        wait (pending_bytes.size() == 0 && !s_valid && digest_words.size() == 0);
    endtask

    initial begin
        sha256_pkg::in_item_t it;
        error_count = 0;
        cycle_count = 0;
        items_queued = 0;
        hold_sender = 0;
        in_taken = 0;
        gaps_on = 1;
        s_valid = 0;
        s_data = '0;
        m_ready = 0;
        hash_clear();
        // directed: empty message, extremes of byte values
        add_message(0, 1);
        it = '{data_byte: 8'hff, has_byte: 1'b1, is_last: 1'b1};
        push_item(it);
        it = '{data_byte: 8'h00, has_byte: 1'b1, is_last: 1'b0};
        push_item(it);
        it = '{data_byte: 8'hff, has_byte: 1'b0, is_last: 1'b0};
        push_item(it);
        it = '{data_byte: 8'h55, has_byte: 1'b0, is_last: 1'b1};
        push_item(it);
        wait (aresetn);
        drain();
        // all digests are out; pause sender before the next group
        hold_sender = 1;
        repeat (20) @(posedge aclk);
        hold_sender = 0;
        // padding boundary lengths: fits, spills into a second block, full block
        add_message(55, 0);
        add_message(56, 0);
        add_message(63, 1);
        add_message(64, 0);
        drain();
        // random messages, mostly short
        while (items_queued < 320) begin
            int len;
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 130) : $urandom_range(0, 20);
            add_message(len, $urandom_range(0, 3) == 0);
            if ($urandom_range(0, 5) == 0) begin
                gaps_on = !gaps_on;
            end
        end
        gaps_on = 1;
        drain();
        repeat (300) @(posedge aclk);
        if (error_count == 0 && digest_words.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

### files.f
rtl/sha256_pkg.sv
rtl/sha256_queue.sv
rtl/sha256_core.sv
rtl/sha256_stream_hasher_unit.sv
test/tb.sv
